// ===== hdl/sbc_pkg.sv =====
// sbc_pkg: widths, payload types and sideband records for the segment/box clipper.
// No dependencies; imported by every file under hdl.
package sbc_pkg;

    localparam int COORD_WIDTH   = 24;
    localparam int FRACTION_BITS = 16;
    localparam int MAG_W         = COORD_WIDTH + 1;     // |difference| of two coordinates
    localparam int PROD_W        = 2 * MAG_W;           // |dy| * |x offset|
    localparam int FRAC_W        = FRACTION_BITS + 1;   // fraction incl. the 1.0 code

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [MAG_W-1:0]       diff_t;
    typedef logic [MAG_W-1:0]              mag_t;
    typedef logic [FRAC_W-1:0]             frac_t;

    localparam frac_t FRAC_ONE = frac_t'(1) << FRACTION_BITS;

    typedef struct packed {
        coord_t box_lo_x;
        coord_t box_lo_y;
        coord_t box_hi_x;
        coord_t box_hi_y;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } sbc_req_t;

    typedef struct packed {
        logic  hit;
        frac_t entry_frac;
        frac_t exit_frac;
    } sbc_res_t;

    // travels alongside the line-y divider
    typedef struct packed {
        logic   miss;
        logic   dx_zero;
        logic   neg0;
        logic   neg1;
        logic   keep0;
        logic   keep1;
        coord_t sx;
        coord_t sy;
        coord_t ex;
        coord_t ey;
        coord_t ly;
        coord_t hy;
        coord_t mnx;
        coord_t mxx;
        mag_t   mag_dx;
        mag_t   mag_dy;
    } sbc_yside_t;

    // travels alongside the fraction divider
    typedef struct packed {
        logic miss;
        logic zlen;
    } sbc_fside_t;

endpackage

// ===== hdl/sbc_div.sv =====
// sbc_div: pipelined restoring divider, one quotient bit per register stage,
// two numerators over a shared divisor plus a sideband. Depends on sbc_pkg.
module sbc_div
    import sbc_pkg::*;
#(
    parameter int DW    = MAG_W,
    parameter int STEPS = MAG_W,
    parameter int SBW   = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [DW-1:0]    rem_a,      // leading dividend bits, below divisor
    input  logic [DW-1:0]    rem_b,
    input  logic [STEPS-1:0] bits_a,     // remaining dividend bits, msb first
    input  logic [STEPS-1:0] bits_b,
    input  logic [DW-1:0]    divisor,
    input  logic [SBW-1:0]   side_in,
    output logic             out_valid,
    output logic [STEPS-1:0] quo_a,
    output logic [STEPS-1:0] quo_b,
    output logic             rnz_a,
    output logic             rnz_b,
    output logic [SBW-1:0]   side_out
);

    logic             vld_reg [1:STEPS];
    logic [DW-1:0]    ra_reg  [1:STEPS];
    logic [DW-1:0]    rb_reg  [1:STEPS];
    logic [DW-1:0]    dv_reg  [1:STEPS];
    logic [STEPS-1:0] qa_reg  [1:STEPS];
    logic [STEPS-1:0] qb_reg  [1:STEPS];
    logic [STEPS-1:0] ba_reg  [1:STEPS];
    logic [STEPS-1:0] bb_reg  [1:STEPS];
    logic [SBW-1:0]   sd_reg  [1:STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic             cv;
        logic [DW-1:0]    cra;
        logic [DW-1:0]    crb;
        logic [DW-1:0]    cdv;
        logic [STEPS-1:0] cqa;
        logic [STEPS-1:0] cqb;
        logic [STEPS-1:0] cba;
        logic [STEPS-1:0] cbb;
        logic [SBW-1:0]   csd;
        logic [DW:0]      ta;
        logic [DW:0]      tb;
        logic [DW:0]      da;
        logic [DW:0]      db;
        logic             ga;
        logic             gb;
        logic [DW-1:0]    ra_next;
        logic [DW-1:0]    rb_next;

        if (i == 0)
        begin : g_head
            assign cv  = in_valid;
            assign cra = rem_a;
            assign crb = rem_b;
            assign cdv = divisor;
            assign cqa = '0;
            assign cqb = '0;
            assign cba = bits_a;
            assign cbb = bits_b;
            assign csd = side_in;
        end
        else
        begin : g_body
            assign cv  = vld_reg[i];
            assign cra = ra_reg[i];
            assign crb = rb_reg[i];
            assign cdv = dv_reg[i];
            assign cqa = qa_reg[i];
            assign cqb = qb_reg[i];
            assign cba = ba_reg[i];
            assign cbb = bb_reg[i];
            assign csd = sd_reg[i];
        end

        always_comb
        begin
            ta      = {cra, cba[STEPS-1]};
            tb      = {crb, cbb[STEPS-1]};
            da      = ta - {1'b0, cdv};
            db      = tb - {1'b0, cdv};
            ga      = ta >= {1'b0, cdv};
            gb      = tb >= {1'b0, cdv};
            ra_next = ga ? da[DW-1:0] : ta[DW-1:0];
            rb_next = gb ? db[DW-1:0] : tb[DW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= cv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ra_reg[i+1] <= ra_next;
                rb_reg[i+1] <= rb_next;
                dv_reg[i+1] <= cdv;
                qa_reg[i+1] <= {cqa[STEPS-2:0], ga};
                qb_reg[i+1] <= {cqb[STEPS-2:0], gb};
                ba_reg[i+1] <= cba << 1;
                bb_reg[i+1] <= cbb << 1;
                sd_reg[i+1] <= csd;
            end
        end
    end

    assign out_valid = vld_reg[STEPS];
    assign quo_a     = qa_reg[STEPS];
    assign quo_b     = qb_reg[STEPS];
    assign rnz_a     = ra_reg[STEPS] != '0;
    assign rnz_b     = rb_reg[STEPS] != '0;
    assign side_out  = sd_reg[STEPS];

endmodule

// ===== hdl/segment_box_clip_top.sv =====
// segment_box_clip_top: clips a line segment against an axis-aligned box.
// Depends on sbc_pkg and sbc_div.
//
// Usage
//   Request channel (req_valid / req_stall / req): one segment and one box.
//   Result channel (res_valid / res_stall / res): exactly one result per
//   request, in order: hit flag plus entry and exit fractions (Q1.16 style,
//   FRAC_ONE = 1.0), both zero on a miss.
// Throughput: one request per cycle, sustained, when the result side is not
//   stalling.
// Depth: set mostly by the two bit-per-stage dividers, with COORD_WIDTH+1 stages for the line
//   y values and FRACTION_BITS+1 stages for the fractions.
// Stall: the whole pipeline holds while a result waits under res_stall;
//   req_stall is raised in the same cycle, so nothing is dropped or repeated.
//   Bubbles travel as cleared valid bits.
// Reset: all valid bits clear asynchronously; no request is in flight after
//   reset and there is no clearing pass.
module segment_box_clip_top
    import sbc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  sbc_req_t req,
    output logic     res_valid,
    input  logic     res_stall,
    output sbc_res_t res
);

    function automatic diff_t sx1(input coord_t v);
        return {v[COORD_WIDTH-1], v};
    endfunction

    function automatic mag_t mag_of(input diff_t v);
        return v[MAG_W-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

    // sy -/+ q, rounded toward minus infinity; result lies between the endpoints
    function automatic coord_t line_y(input coord_t sy, input logic keep, input logic neg,
                                      input mag_t q, input logic rnz);
        logic signed [MAG_W:0] ys;
        logic signed [MAG_W:0] qq;
        logic signed [MAG_W:0] sum;
        ys  = {sy[COORD_WIDTH-1], sy[COORD_WIDTH-1], sy};
        // a remainder only pushes a negative step one further down
        qq  = $signed({1'b0, q}) + $signed({{MAG_W{1'b0}}, neg & rnz});
        sum = neg ? ys - qq : ys + qq;
        return keep ? sy : sum[COORD_WIDTH-1:0];
    endfunction

    function automatic frac_t sat_frac(input frac_t q);
        return (q > FRAC_ONE) ? FRAC_ONE : q;
    endfunction

    logic en;
    logic res_valid_reg;
    sbc_res_t res_reg;

    // one enable for the whole pipe: hold everything while the result waits
    assign en        = !(res_valid_reg && res_stall);
    assign req_stall = !en;

    // ---------------- stage A: request register
    logic     a_valid_reg;
    sbc_req_t a_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_req_reg <= req;
        end
    end

    // ---------------- stage B: edge-line reject, x clip
    coord_t b_lo_x, b_hi_x, b_mnx_next, b_mxx_next;
    logic   b_miss_next;
    diff_t  b_dx_next, b_dy_next;

    always_comb
    begin
        b_dx_next  = sx1(a_req_reg.end_x) - sx1(a_req_reg.start_x);
        b_dy_next  = sx1(a_req_reg.end_y) - sx1(a_req_reg.start_y);
        b_lo_x     = (a_req_reg.start_x < a_req_reg.end_x) ? a_req_reg.start_x : a_req_reg.end_x;
        b_hi_x     = (a_req_reg.start_x > a_req_reg.end_x) ? a_req_reg.start_x : a_req_reg.end_x;
        b_mnx_next = (a_req_reg.box_lo_x > b_lo_x) ? a_req_reg.box_lo_x : b_lo_x;
        b_mxx_next = (a_req_reg.box_hi_x < b_hi_x) ? a_req_reg.box_hi_x : b_hi_x;
        // segment lying on a box edge line is a miss, as is an empty x-span
        b_miss_next = (a_req_reg.start_x == a_req_reg.end_x &&
                       (a_req_reg.start_x == a_req_reg.box_lo_x ||
                        a_req_reg.start_x == a_req_reg.box_hi_x)) ||
                      (a_req_reg.start_y == a_req_reg.end_y &&
                       (a_req_reg.start_y == a_req_reg.box_lo_y ||
                        a_req_reg.start_y == a_req_reg.box_hi_y)) ||
                      (b_mnx_next > b_mxx_next);
    end

    logic     b_valid_reg;
    logic     b_miss_reg;
    sbc_req_t b_req_reg;
    coord_t   b_mnx_reg, b_mxx_reg;
    diff_t    b_dx_reg, b_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_miss_reg <= b_miss_next;
            b_req_reg  <= a_req_reg;
            b_mnx_reg  <= b_mnx_next;
            b_mxx_reg  <= b_mxx_next;
            b_dx_reg   <= b_dx_next;
            b_dy_reg   <= b_dy_next;
        end
    end

    // ---------------- stage C: x offsets, magnitudes and signs
    diff_t      c_off0, c_off1;
    sbc_yside_t c_side_next;

    always_comb
    begin
        c_off0              = sx1(b_mnx_reg) - sx1(b_req_reg.start_x);
        c_off1              = sx1(b_mxx_reg) - sx1(b_req_reg.start_x);
        c_side_next.miss    = b_miss_reg;
        c_side_next.dx_zero = b_dx_reg == '0;
        c_side_next.neg0    = b_dy_reg[MAG_W-1] ^ c_off0[MAG_W-1] ^ b_dx_reg[MAG_W-1];
        c_side_next.neg1    = b_dy_reg[MAG_W-1] ^ c_off1[MAG_W-1] ^ b_dx_reg[MAG_W-1];
        c_side_next.keep0   = (b_dy_reg == '0) || (c_off0 == '0);
        c_side_next.keep1   = (b_dy_reg == '0) || (c_off1 == '0);
        c_side_next.sx      = b_req_reg.start_x;
        c_side_next.sy      = b_req_reg.start_y;
        c_side_next.ex      = b_req_reg.end_x;
        c_side_next.ey      = b_req_reg.end_y;
        c_side_next.ly      = b_req_reg.box_lo_y;
        c_side_next.hy      = b_req_reg.box_hi_y;
        c_side_next.mnx     = b_mnx_reg;
        c_side_next.mxx     = b_mxx_reg;
        c_side_next.mag_dx  = mag_of(b_dx_reg);
        c_side_next.mag_dy  = mag_of(b_dy_reg);
    end

    logic       c_valid_reg;
    sbc_yside_t c_side_reg;
    mag_t       c_moff0_reg, c_moff1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_side_reg  <= c_side_next;
            c_moff0_reg <= mag_of(c_off0);
            c_moff1_reg <= mag_of(c_off1);
        end
    end

    // ---------------- stage D: |dy| * |offset| at both clipped x limits
    logic              d_valid_reg;
    sbc_yside_t        d_side_reg;
    logic [PROD_W-1:0] d_prod0_reg, d_prod1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_side_reg  <= c_side_reg;
            d_prod0_reg <= PROD_W'(c_side_reg.mag_dy) * PROD_W'(c_moff0_reg);
            d_prod1_reg <= PROD_W'(c_side_reg.mag_dy) * PROD_W'(c_moff1_reg);
        end
    end

    // ---------------- line y divider: quotient <= |dy|, so MAG_W steps
    logic       y_valid;
    mag_t       y_q0, y_q1;
    logic       y_rnz0, y_rnz1;
    sbc_yside_t y_side;

    sbc_div #(
        .DW    (MAG_W),
        .STEPS (MAG_W),
        .SBW   ($bits(sbc_yside_t))
    ) u_ydiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid_reg),
        .rem_a     (d_prod0_reg[PROD_W-1:MAG_W]),
        .rem_b     (d_prod1_reg[PROD_W-1:MAG_W]),
        .bits_a    (d_prod0_reg[MAG_W-1:0]),
        .bits_b    (d_prod1_reg[MAG_W-1:0]),
        .divisor   (d_side_reg.mag_dx),
        .side_in   (d_side_reg),
        .out_valid (y_valid),
        .quo_a     (y_q0),
        .quo_b     (y_q1),
        .rnz_a     (y_rnz0),
        .rnz_b     (y_rnz1),
        .side_out  (y_side)
    );

    // ---------------- stage E: line y at both limits (vertical: endpoint y)
    logic       e_valid_reg;
    sbc_yside_t e_side_reg;
    coord_t     e_y0_reg, e_y1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= y_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_side_reg <= y_side;
            e_y0_reg   <= y_side.dx_zero ? y_side.sy :
                          line_y(y_side.sy, y_side.keep0, y_side.neg0, y_q0, y_rnz0);
            e_y1_reg   <= y_side.dx_zero ? y_side.ey :
                          line_y(y_side.sy, y_side.keep1, y_side.neg1, y_q1, y_rnz1);
        end
    end

    // ---------------- stage F: sort y pair and clip to the box y-span
    coord_t f_ylo, f_yhi;
    logic       f_valid_reg;
    sbc_yside_t f_side_reg;
    coord_t     f_ylo_reg, f_yhi_reg;

    always_comb
    begin
        f_ylo = (e_y0_reg < e_y1_reg) ? e_y0_reg : e_y1_reg;
        f_yhi = (e_y0_reg < e_y1_reg) ? e_y1_reg : e_y0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_side_reg <= e_side_reg;
            f_ylo_reg  <= (e_side_reg.ly > f_ylo) ? e_side_reg.ly : f_ylo;
            f_yhi_reg  <= (e_side_reg.hy < f_yhi) ? e_side_reg.hy : f_yhi;
        end
    end

    // ---------------- stage G: entry/exit points, dominant axis, numerators
    coord_t     g_nx, g_ny, g_xx, g_xy;
    logic       g_dom_x;
    mag_t       g_num_e_next, g_num_x_next;
    sbc_fside_t g_fside_next;

    always_comb
    begin
        g_nx    = (f_side_reg.sx < f_side_reg.ex) ? f_side_reg.mnx : f_side_reg.mxx;
        g_xx    = (f_side_reg.sx > f_side_reg.ex) ? f_side_reg.mnx : f_side_reg.mxx;
        g_ny    = (f_side_reg.sy < f_side_reg.ey) ? f_ylo_reg : f_yhi_reg;
        g_xy    = (f_side_reg.sy > f_side_reg.ey) ? f_ylo_reg : f_yhi_reg;
        g_dom_x = f_side_reg.mag_dx >= f_side_reg.mag_dy;
        g_num_e_next = g_dom_x ? mag_of(sx1(g_nx) - sx1(f_side_reg.sx)) :
                                 mag_of(sx1(g_ny) - sx1(f_side_reg.sy));
        g_num_x_next = g_dom_x ? mag_of(sx1(g_xx) - sx1(f_side_reg.sx)) :
                                 mag_of(sx1(g_xy) - sx1(f_side_reg.sy));
        g_fside_next.miss = f_side_reg.miss || (f_ylo_reg > f_yhi_reg);
        g_fside_next.zlen = (f_side_reg.mag_dx == '0) && (f_side_reg.mag_dy == '0);
    end

    logic       g_valid_reg;
    sbc_fside_t g_fside_reg;
    mag_t       g_num_e_reg, g_num_x_reg, g_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_fside_reg <= g_fside_next;
            g_num_e_reg <= g_num_e_next;
            g_num_x_reg <= g_num_x_next;
            g_den_reg   <= g_dom_x ? f_side_reg.mag_dx : f_side_reg.mag_dy;
        end
    end

    // ---------------- fraction divider: (num << FRACTION_BITS) / den, num <= den
    logic       q_valid;
    frac_t      q_entry, q_exit;
    sbc_fside_t q_fside;

    sbc_div #(
        .DW    (MAG_W),
        .STEPS (FRAC_W),
        .SBW   ($bits(sbc_fside_t))
    ) u_fdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid_reg),
        .rem_a     ({1'b0, g_num_e_reg[MAG_W-1:1]}),
        .rem_b     ({1'b0, g_num_x_reg[MAG_W-1:1]}),
        .bits_a    ({g_num_e_reg[0], {FRACTION_BITS{1'b0}}}),
        .bits_b    ({g_num_x_reg[0], {FRACTION_BITS{1'b0}}}),
        .divisor   (g_den_reg),
        .side_in   (g_fside_reg),
        .out_valid (q_valid),
        .quo_a     (q_entry),
        .quo_b     (q_exit),
        .rnz_a     (),
        .rnz_b     (),
        .side_out  (q_fside)
    );

    // ---------------- stage H: result register
    sbc_res_t res_next;

    always_comb
    begin
        res_next.hit        = !q_fside.miss;
        res_next.entry_frac = (q_fside.miss || q_fside.zlen) ? '0 : sat_frac(q_entry);
        res_next.exit_frac  = q_fside.miss ? '0 :
                              q_fside.zlen ? FRAC_ONE : sat_frac(q_exit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== hdl/sbc_chk.sv =====
// sbc_chk: port-level checks on segment_box_clip_top, attached by bind.
// Depends on sbc_pkg.
module sbc_chk
    import sbc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input sbc_req_t req,
    input logic     res_valid,
    input logic     res_stall,
    input sbc_res_t res
);

    // a waiting result holds still
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res)))
        else $error("result changed while stalled");

    // back-pressure only comes from a blocked result
    a_req_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall))
        else $error("request stalled without a blocked result");

    // a miss carries zero fractions
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res.hit) |-> (res.entry_frac == '0 && res.exit_frac == '0))
        else $error("miss with non-zero fraction");

    // entry never lies beyond exit, and exit never beyond 1.0
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.hit) |-> (res.entry_frac <= res.exit_frac &&
                                    res.exit_frac <= FRAC_ONE))
        else $error("hit fractions out of order");

endmodule

bind segment_box_clip_top sbc_chk u_sbc_chk (.*);

// ===== dv/segment_box_clip_top_tb.sv =====
// segment_box_clip_top_tb: self-checking bench for the segment/box clipper.
// Depends on sbc_pkg and the RTL under hdl; predicts each result in-bench.
// Directed edge cases, then random segments biased towards the box.
module segment_box_clip_top_tb;
    import sbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = COORD_WIDTH + FRACTION_BITS + 10;
    localparam int N_RANDOM  = 1150;
    localparam int IDLE_MAX  = 12;
    localparam int HOLD_LONG = 300;

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_stall;
    sbc_req_t req;
    logic     res_valid;
    logic     res_stall;
    sbc_res_t res;

    segment_box_clip_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    sbc_req_t pending_reqs[$];   // requests not yet offered
    sbc_res_t expected_clips[$]; // predictions awaiting the result side
    int       n_errors;
    bit       stim_done;
    bit       long_hold;         // raised once to force back-pressure

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // floor(dy*off/dx), dx != 0, exact in 128 bits
    function automatic longint line_y_at(longint sx, longint sy, longint dx,
                                         longint dy, longint x);
        logic signed [127:0] num;
        logic signed [127:0] q;
        logic signed [127:0] r;
        begin
            num = 128'(dy) * 128'(x - sx);
            q   = num / 128'(dx);
            r   = num % 128'(dx);
            // truncation went the wrong way for a negative quotient
            if (r != 0 && ((r < 0) != (dx < 0)))
                q = q - 1;
            return sy + longint'(q);
        end
    endfunction

    function automatic longint abs_l(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic frac_t frac_along(longint p, longint s, longint d);
        longint t;
        begin
            if (d == 0)
                return '0;
            t = (abs_l(p - s) << FRACTION_BITS) / abs_l(d);
            if (t > (longint'(1) << FRACTION_BITS))
                t = longint'(1) << FRACTION_BITS;
            return frac_t'(t);
        end
    endfunction

    function automatic sbc_res_t clip_predict(sbc_req_t q);
        longint   lx, ly, hx, hy, sx, sy, ex, ey, dx, dy;
        longint   mnx, mxx, y0, y1, t, nx, ny, xx, xy;
        sbc_res_t r;
        begin
            lx = q.box_lo_x; ly = q.box_lo_y;
            hx = q.box_hi_x; hy = q.box_hi_y;
            sx = q.start_x;  sy = q.start_y;
            ex = q.end_x;    ey = q.end_y;
            dx = ex - sx;    dy = ey - sy;
            r  = '0;
            // lying along a box edge line is a miss
            if (sx == ex && (sx == lx || sx == hx))
                return r;
            if (sy == ey && (sy == ly || sy == hy))
                return r;
            mnx = (sx < ex) ? sx : ex;
            if (lx > mnx) mnx = lx;
            mxx = (sx > ex) ? sx : ex;
            if (hx < mxx) mxx = hx;
            if (mnx > mxx)
                return r;
            if (dx != 0)
            begin
                y0 = line_y_at(sx, sy, dx, dy, mnx);
                y1 = line_y_at(sx, sy, dx, dy, mxx);
            end
            else
            begin
                y0 = sy;
                y1 = ey;
            end
            if (y0 > y1)
            begin
                t = y0; y0 = y1; y1 = t;
            end
            if (ly > y0) y0 = ly;
            if (hy < y1) y1 = hy;
            if (y0 > y1)
                return r;
            nx = (sx < ex) ? mnx : mxx;
            ny = (sy < ey) ? y0 : y1;
            xx = (sx > ex) ? mnx : mxx;
            xy = (sy > ey) ? y0 : y1;
            r.hit = 1'b1;
            if (dx == 0 && dy == 0)
            begin
                r.entry_frac = '0;
                r.exit_frac  = FRAC_ONE;
            end
            else if (abs_l(dx) >= abs_l(dy))
            begin
                r.entry_frac = frac_along(nx, sx, dx);
                r.exit_frac  = frac_along(xx, sx, dx);
            end
            else
            begin
                r.entry_frac = frac_along(ny, sy, dy);
                r.exit_frac  = frac_along(xy, sy, dy);
            end
            return r;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    localparam longint CMAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
    localparam longint CMIN = -(longint'(1) << (COORD_WIDTH - 1));

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    // coordinate near a centre, clamped to the field's range
    function automatic coord_t near(longint c, int spread);
        longint v;
        begin
            v = c + longint'($urandom_range(2 * spread, 0)) - spread;
            if (v > CMAX) v = CMAX;
            if (v < CMIN) v = CMIN;
            return coord_t'(v);
        end
    endfunction

    function automatic sbc_req_t mk_req(longint lx, longint ly, longint hx,
                                        longint hy, longint sx, longint sy,
                                        longint ex, longint ey);
        sbc_req_t q;
        begin
            q.box_lo_x = coord_t'(lx); q.box_lo_y = coord_t'(ly);
            q.box_hi_x = coord_t'(hx); q.box_hi_y = coord_t'(hy);
            q.start_x  = coord_t'(sx); q.start_y  = coord_t'(sy);
            q.end_x    = coord_t'(ex); q.end_y    = coord_t'(ey);
            return q;
        end
    endfunction

    // append a request to the tail of the pending queue
    function automatic void queue_req(sbc_req_t q);
        pending_reqs.insert(pending_reqs.size(), q);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus: directed first, then random
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        sbc_req_t q;
        longint   cx, cy;
        int       w, h, spread, kind;

        n_errors  = 0;
        stim_done = 1'b0;

        // crossing diagonally, shallow and steep, both directions
        queue_req(mk_req(0, 0, 100, 100, -50, -50, 150, 150));
        queue_req(mk_req(0, 0, 100, 100, 150, 20, -50, 70));
        queue_req(mk_req(0, 0, 100, 100, 30, 200, 60, -90));
        // fully inside, and starting inside
        queue_req(mk_req(-10, -10, 10, 10, -3, 4, 5, -7));
        queue_req(mk_req(-10, -10, 10, 10, 0, 0, 40, 13));
        // vertical and horizontal on each edge line: misses
        queue_req(mk_req(0, 0, 100, 100, 0, -20, 0, 120));
        queue_req(mk_req(0, 0, 100, 100, 100, -20, 100, 120));
        queue_req(mk_req(0, 0, 100, 100, -20, 0, 120, 0));
        queue_req(mk_req(0, 0, 100, 100, -20, 100, 120, 100));
        // vertical and horizontal through the interior
        queue_req(mk_req(0, 0, 100, 100, 50, 120, 50, -20));
        queue_req(mk_req(0, 0, 100, 100, 120, 50, -20, 50));
        // zero-length segment inside and outside
        queue_req(mk_req(0, 0, 100, 100, 40, 40, 40, 40));
        queue_req(mk_req(0, 0, 100, 100, 140, 40, 140, 40));
        // touching a corner from outside counts as a hit
        queue_req(mk_req(0, 0, 100, 100, 90, 110, 110, 90));
        queue_req(mk_req(0, 0, 100, 100, -10, 10, 10, -10));
        // inverted box
        queue_req(mk_req(100, 100, 0, 0, -50, -50, 150, 150));
        // disjoint in x, then in y only
        queue_req(mk_req(0, 0, 100, 100, 200, 0, 300, 100));
        queue_req(mk_req(0, 0, 100, 100, -50, 300, 150, 200));
        // full-range extremes
        queue_req(mk_req(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN, CMAX, CMAX));
        queue_req(mk_req(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX));
        queue_req(mk_req(-1, -1, 1, 1, CMAX, CMIN + 1, CMIN, CMAX));
        queue_req(mk_req(CMIN, CMIN, CMAX, CMAX, CMIN, 5, CMAX, 4));
        queue_req(mk_req(CMAX, CMAX, CMIN, CMIN, 0, 0, 1, 1));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(9, 0);
            if (kind < 2)
            begin
                // fully random bits
                q = sbc_req_t'({$urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom});
            end
            else
            begin
                // box around a random centre, segment placed near it
                spread = (kind < 5) ? 64 : ((kind < 8) ? 40000 : 4000000);
                cx = rand_coord();
                cy = rand_coord();
                w  = $urandom_range(spread, 0);
                h  = $urandom_range(spread, 0);
                q.box_lo_x = near(cx - w, 2);
                q.box_lo_y = near(cy - h, 2);
                q.box_hi_x = near(cx + w, 2);
                q.box_hi_y = near(cy + h, 2);
                q.start_x  = near(cx, 2 * spread + 2);
                q.start_y  = near(cy, 2 * spread + 2);
                q.end_x    = near(cx, 2 * spread + 2);
                q.end_y    = near(cy, 2 * spread + 2);
                // occasionally axis-aligned, on an edge line or not
                case ($urandom_range(7, 0))
                    0: q.end_x = q.start_x;
                    1: q.end_y = q.start_y;
                    2: begin q.start_x = q.box_lo_x; q.end_x = q.box_lo_x; end
                    3: begin q.start_y = q.box_hi_y; q.end_y = q.box_hi_y; end
                    default: ;
                endcase
            end
            queue_req(q);
        end
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // Reset
    // ---------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Driver: offers requests with random gaps; the payload holds while
    // stalled and valid never looks at the stall.
    // ---------------------------------------------------------------
    int req_gap;
    int reqs_sent;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            req_gap   <= 0;
            reqs_sent <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                // accepted: predict now, then decide on the next one
                expected_clips.insert(expected_clips.size(), clip_predict(req));
                reqs_sent <= reqs_sent + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (req_gap > 0)
                begin
                    req_valid <= 1'b0;
                    req_gap   <= req_gap - 1;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req_valid <= 1'b1;
                    req       <= pending_reqs.pop_front();
                    // bursts without gaps part of the time
                    req_gap   <= ($urandom_range(3, 0) == 0) ? 0
                                 : $urandom_range(IDLE_MAX, 0);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Long hold: counted on its own, once, early in the run
    // ---------------------------------------------------------------
    int hold_count;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            long_hold  <= 1'b0;
        end
        else if (!long_hold && reqs_sent >= 40)
        begin
            // start of the long hold: the pipeline must back up
            long_hold  <= 1'b1;
            hold_count <= HOLD_LONG;
        end
        else if (hold_count > 0)
        begin
            hold_count <= hold_count - 1;
        end
    end

    // ---------------------------------------------------------------
    // Result side: random stalls, and stalled throughout the long hold
    // ---------------------------------------------------------------
    int res_wait;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b1;
            res_wait  <= 0;
        end
        else if (hold_count > 0)
        begin
            res_stall <= 1'b1;
        end
        else if (res_wait > 0)
        begin
            res_wait  <= res_wait - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= 1'b0;
            if (res_valid && !res_stall)
                res_wait <= ($urandom_range(2, 0) == 0) ? 0
                            : $urandom_range(IDLE_MAX, 0);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        sbc_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_clips.size() == 0)
            begin
                $error("result with no request outstanding: %p", res);
                n_errors = n_errors + 1;
            end
            else
            begin
                want = expected_clips.pop_front();
                if (res.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, res.hit);
                    n_errors = n_errors + 1;
                end
                if (res.entry_frac !== want.entry_frac)
                begin
                    $error("entry_frac: expected %0d, got %0d",
                           want.entry_frac, res.entry_frac);
                    n_errors = n_errors + 1;
                end
                if (res.exit_frac !== want.exit_frac)
                begin
                    $error("exit_frac: expected %0d, got %0d",
                           want.exit_frac, res.exit_frac);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // End of run
    // ---------------------------------------------------------------
    initial
    begin
        wait (stim_done);
        @(posedge clk);
        while (pending_reqs.size() > 0 || req_valid || expected_clips.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (n_errors == 0 && expected_clips.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog: far above the slowest legal run
    initial
    begin
        #(20ns * 200000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sbc_pkg.sv
hdl/sbc_div.sv
hdl/segment_box_clip_top.sv
hdl/sbc_chk.sv
dv/segment_box_clip_top_tb.sv
